@@ hdl/xfc_pkg.sv @@
`default_nettype none

package xfc_pkg;

    localparam int XFC_BUFFER_BYTES = 64;
    // start, command, length, check and two stop bytes
    localparam int XFC_FRAME_OVERHEAD = 6;

    localparam int XFC_CFG_INDEX_W = 2;

    localparam logic [XFC_CFG_INDEX_W-1:0] CFG_START_MARKER    = 2'd0;
    localparam logic [XFC_CFG_INDEX_W-1:0] CFG_STOP_MARKER_ONE = 2'd1;
    localparam logic [XFC_CFG_INDEX_W-1:0] CFG_STOP_MARKER_TWO = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CHECK_BAD = 2'd1;
    localparam logic [1:0] STATUS_MARK_BAD  = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_STOP1   = 3'd5,
        PH_STOP2   = 3'd6
    } xfc_phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_begin;
    } xfc_item_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] stop_marker_one;
        logic [7:0] stop_marker_two;
    } xfc_cfg_t;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] computed_check;
    } xfc_result_t;

endpackage

`default_nettype wire

@@ hdl/xfc_parser.sv @@
`default_nettype none

module xfc_parser
    import xfc_pkg::*;
#(
    parameter int BUFFER_BYTES = XFC_BUFFER_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire xfc_item_t   item,
    input  wire xfc_cfg_t    cfg,
    input  wire logic        out_free,
    output logic             item_take,
    output logic             res_valid,
    output xfc_result_t      res
);

    // longest length byte whose whole frame still fits the buffer
    localparam int LenLimit = BUFFER_BYTES - XFC_FRAME_OVERHEAD;

    xfc_phase_t phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_check_reg, running_check_next;
    logic [7:0] held_command_reg, held_command_next;
    logic [7:0] held_length_reg, held_length_next;
    logic       markers_good_reg, markers_good_next;
    logic       check_good_reg, check_good_next;

    logic       too_long;
    logic [7:0] bytes_dec;

    assign item_take = item_valid && out_free;
    assign too_long  = {1'b0, item.rx_byte} > 9'(LenLimit);
    assign bytes_dec = bytes_left_reg - 8'd1;

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        running_check_next = running_check_reg;
        held_command_next  = held_command_reg;
        held_length_next   = held_length_reg;
        markers_good_next  = markers_good_reg;
        check_good_next    = check_good_reg;
        if (item_take)
        begin
            if (item.frame_begin)
            begin
                markers_good_next  = (item.rx_byte == cfg.start_marker);
                check_good_next    = 1'b1;
                running_check_next = '0;
                bytes_left_next    = '0;
                phase_next         = PH_CMD;
            end
            else
            begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        held_command_next  = item.rx_byte;
                        running_check_next = item.rx_byte;
                        phase_next         = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        held_length_next   = item.rx_byte;
                        running_check_next = running_check_reg ^ item.rx_byte;
                        if (too_long)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            bytes_left_next = item.rx_byte;
                            phase_next = (item.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        running_check_next = running_check_reg ^ item.rx_byte;
                        bytes_left_next    = bytes_dec;
                        if (bytes_dec == 8'd0)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        check_good_next = (item.rx_byte == running_check_reg);
                        phase_next      = PH_STOP1;
                    end
                    PH_STOP1:
                    begin
                        if (item.rx_byte != cfg.stop_marker_one)
                        begin
                            markers_good_next = 1'b0;
                        end
                        phase_next = PH_STOP2;
                    end
                    PH_STOP2:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // verdict
    always_comb
    begin
        res_valid          = 1'b0;
        res.frame_status   = STATUS_OK;
        res.command_code   = held_command_reg;
        res.payload_length = held_length_next;
        res.computed_check = running_check_next;
        if (item_take && !item.frame_begin)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    res_valid        = too_long;
                    res.frame_status = STATUS_TOO_LONG;
                end
                PH_STOP2:
                begin
                    res_valid = 1'b1;
                    // checksum mismatch outranks a marker error
                    if (!check_good_reg)
                    begin
                        res.frame_status = STATUS_CHECK_BAD;
                    end
                    else if (!markers_good_reg || (item.rx_byte != cfg.stop_marker_two))
                    begin
                        res.frame_status = STATUS_MARK_BAD;
                    end
                    else
                    begin
                        res.frame_status = STATUS_OK;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bytes_left_reg    <= '0;
            running_check_reg <= '0;
            held_command_reg  <= '0;
            held_length_reg   <= '0;
            markers_good_reg  <= 1'b1;
            check_good_reg    <= 1'b1;
        end
        else
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            running_check_reg <= running_check_next;
            held_command_reg  <= held_command_next;
            held_length_reg   <= held_length_next;
            markers_good_reg  <= markers_good_next;
            check_good_reg    <= check_good_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/xfc_out_stage.sv @@
`default_nettype none

module xfc_out_stage
    import xfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire xfc_result_t res,
    output logic             out_free,
    output logic             out_valid,
    input  wire logic        out_ready,
    output xfc_result_t      out_res
);

    logic        valid_reg, valid_next;
    xfc_result_t data_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // the parser only fires while the slot is free
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ hdl/xor_frame_checker.sv @@
// channel  handshake              payload
// in       in_valid / in_ready    rx_byte, frame_begin
// out      out_valid / out_ready  frame_status, command_code, payload_length, computed_check
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte per cycle while the output register is not stalled: a beat lands in the
// input register, the parser updates its state from it and drops a verdict into the
// output register.
// cfg_ready is always high; cfg_reg and the valid flags clear to zero on reset.
// a stalled output register holds the parser, which in turn holds in_ready low
// once the input register is full.
`default_nettype none

module xor_frame_checker
    import xfc_pkg::*;
#(
    parameter int BUFFER_BYTES = XFC_BUFFER_BYTES
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 rx_byte,
    input  wire logic                       frame_begin,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      frame_status,
    output logic [7:0]                      command_code,
    output logic [7:0]                      payload_length,
    output logic [7:0]                      computed_check,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [XFC_CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                 cfg_data
);

    logic        hold_valid_reg, hold_valid_next;
    xfc_item_t   hold_item_reg;
    xfc_cfg_t    cfg_reg;
    logic        item_take;
    logic        res_valid;
    xfc_result_t res;
    logic        out_free;
    xfc_result_t out_res;
    logic        in_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_MARKER:    cfg_reg.start_marker    <= cfg_data;
                CFG_STOP_MARKER_ONE: cfg_reg.stop_marker_one <= cfg_data;
                CFG_STOP_MARKER_TWO: cfg_reg.stop_marker_two <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    assign in_ready        = !hold_valid_reg || item_take;
    assign in_fire         = in_valid && in_ready;
    assign hold_valid_next = in_fire || (hold_valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_item_reg.rx_byte     <= rx_byte;
            hold_item_reg.frame_begin <= frame_begin;
        end
    end

    xfc_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (hold_valid_reg),
        .item       (hold_item_reg),
        .cfg        (cfg_reg),
        .out_free   (out_free),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    xfc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign frame_status   = out_res.frame_status;
    assign command_code   = out_res.command_code;
    assign payload_length = out_res.payload_length;
    assign computed_check = out_res.computed_check;

endmodule

`default_nettype wire
